/* rtl/core/dopq_pkg.sv */
`timescale 1ns / 1ps

package dopq_pkg;

   // command codes
   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_DRAIN = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_STATS = 2'd3;

   // register indexes
   localparam logic REG_MAX_ENTRIES = 1'b0;
   localparam logic REG_MAX_BYTES   = 1'b1;

   localparam int unsigned CMD_W     = 2;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned TAG_W     = 32;
   localparam int unsigned OCC_W     = 7;
   localparam int unsigned BYTES_W   = 22;
   localparam int unsigned CNT_W     = 32;
   localparam int unsigned MAXB_W    = 24;
   localparam int unsigned CSR_W     = 24;

   localparam logic [LEN_W-1:0]  MAX_LENGTH        = 16'd65535;
   localparam logic [OCC_W-1:0]  MAX_ENTRIES_RESET = 7'd64;
   localparam logic [MAXB_W-1:0] MAX_BYTES_RESET   = 24'hFFFFFF;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DRAIN
   } state_type;

   typedef struct packed {
      logic strobe;
      logic has_entry;
      logic last;
      logic kept_all;
   } rsp_flags_type;

   function automatic logic [LEN_W-1:0] sat_length(input logic [LEN_W-1:0] len);
      sat_length = (len > MAX_LENGTH) ? MAX_LENGTH : len;
   endfunction

endpackage

/* rtl/core/drop_oldest_packet_queue.sv */
`timescale 1ns / 1ps

// Drop-oldest packet descriptor queue.
// Command channel: pulse start with req_command (push, drain, clear, reset
// statistics) and, for a push, req_packet_length and req_packet_tag. A beat
// is taken at a clock edge with start high and busy low; busy stays high
// while a push or a drain is being worked.
// Result channel: rsp_strobe marks each result beat for one cycle; the
// receiver cannot stall it. Every beat carries occupancy, byte total and the
// statistics as they stand after the command.
// Timing: clear, reset-statistics and an empty drain give their beat the
// cycle after acceptance and never raise busy. A push works one
// compare/subtract step per displaced head entry on the shared datapath,
// then the append. A drain of N entries streams one beat per cycle, each
// entry coming from the registered read port of the descriptor memory.
// Config: csr_write writes max_entries (index 0) or max_bytes (index 1);
// only write while idle.
// Reset: queue empty, statistics zero, limits at 64 entries and 16777215
// bytes; memory contents are not cleared, so no clearing pass is needed.
module drop_oldest_packet_queue #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic [15:0]                   req_packet_length,
   input  logic [31:0]                   req_packet_tag,
   output logic                          rsp_strobe,
   output logic                          rsp_has_entry,
   output logic [31:0]                   rsp_entry_tag,
   output logic [15:0]                   rsp_entry_length,
   output logic                          rsp_last,
   output logic                          rsp_kept_all,
   output logic [6:0]                    rsp_occupancy,
   output logic [21:0]                   rsp_byte_total,
   output logic [31:0]                   rsp_pushed_count,
   output logic [31:0]                   rsp_dropped_count,
   output logic [31:0]                   rsp_drained_count,
   output logic [6:0]                    rsp_peak_occupancy,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [23:0]                   csr_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // limit registers
   logic [dopq_pkg::OCC_W-1:0]  max_entries_ff, max_entries_in;
   logic [dopq_pkg::MAXB_W-1:0] max_bytes_ff, max_bytes_in;

   // engine <-> memory
   logic                         wr_en;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic [dopq_pkg::TAG_W-1:0]   wr_tag, rd_tag;
   logic [dopq_pkg::LEN_W-1:0]   wr_len, rd_len;

   // result state
   dopq_pkg::rsp_flags_type      rsp_flags;
   logic [CW-1:0]                count, peak;
   logic [dopq_pkg::BYTES_W-1:0] bytes_held;
   logic [dopq_pkg::CNT_W-1:0]   pushes, drops, drains;

   always_comb begin
      max_entries_in = max_entries_ff;
      max_bytes_in   = max_bytes_ff;
      if (csr_write) begin
         case (csr_index)
            dopq_pkg::REG_MAX_ENTRIES: max_entries_in = csr_data[dopq_pkg::OCC_W-1:0];
            dopq_pkg::REG_MAX_BYTES:   max_bytes_in   = csr_data;
            default: begin
               max_entries_in = max_entries_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= dopq_pkg::MAX_ENTRIES_RESET;
         max_bytes_ff   <= dopq_pkg::MAX_BYTES_RESET;
      end else begin
         max_entries_ff <= max_entries_in;
         max_bytes_ff   <= max_bytes_in;
      end
   end

   dopq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_tag    (wr_tag),
      .wr_len    (wr_len),
      .rd_addr   (rd_addr),
      .rd_tag_ff (rd_tag),
      .rd_len_ff (rd_len)
   );

   dopq_engine #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_packet_length (req_packet_length),
      .req_packet_tag    (req_packet_tag),
      .max_entries       (max_entries_ff),
      .max_bytes         (max_bytes_ff),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_tag            (wr_tag),
      .wr_len            (wr_len),
      .rd_addr           (rd_addr),
      .rd_len            (rd_len),
      .rsp_ff            (rsp_flags),
      .count_ff          (count),
      .bytes_ff          (bytes_held),
      .pushes_ff         (pushes),
      .drops_ff          (drops),
      .drains_ff         (drains),
      .peak_ff           (peak)
   );

   // drained beats take the entry straight from the read register
   assign rsp_strobe         = rsp_flags.strobe;
   assign rsp_has_entry      = rsp_flags.has_entry;
   assign rsp_last           = rsp_flags.last;
   assign rsp_kept_all       = rsp_flags.kept_all;
   assign rsp_entry_tag      = rsp_flags.has_entry ? rd_tag : '0;
   assign rsp_entry_length   = rsp_flags.has_entry ? rd_len : '0;
   assign rsp_occupancy      = dopq_pkg::OCC_W'(count);
   assign rsp_byte_total     = bytes_held;
   assign rsp_pushed_count   = pushes;
   assign rsp_dropped_count  = drops;
   assign rsp_drained_count  = drains;
   assign rsp_peak_occupancy = dopq_pkg::OCC_W'(peak);

endmodule

/* rtl/core/dopq_store.sv */
`timescale 1ns / 1ps

// descriptor memory: one write, one registered read per cycle
module dopq_store #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [dopq_pkg::TAG_W-1:0]    wr_tag,
   input  logic [dopq_pkg::LEN_W-1:0]    wr_len,
   input  logic [AW-1:0]                 rd_addr,
   output logic [dopq_pkg::TAG_W-1:0]    rd_tag_ff,
   output logic [dopq_pkg::LEN_W-1:0]    rd_len_ff
);

   logic [dopq_pkg::TAG_W-1:0] tag_mem [DEPTH];
   logic [dopq_pkg::LEN_W-1:0] len_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr] <= wr_tag;
         len_mem[wr_addr] <= wr_len;
      end
   end

   always_ff @(posedge clock) begin
      rd_tag_ff <= tag_mem[rd_addr];
      rd_len_ff <= len_mem[rd_addr];
   end

endmodule

/* rtl/core/dopq_engine.sv */
`timescale 1ns / 1ps

// sequencer plus the shared add/compare datapath for drops, appends and drains
module dopq_engine #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6,
   parameter int unsigned CW    = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [dopq_pkg::CMD_W-1:0]      req_command,
   input  logic [dopq_pkg::LEN_W-1:0]      req_packet_length,
   input  logic [dopq_pkg::TAG_W-1:0]      req_packet_tag,
   input  logic [dopq_pkg::OCC_W-1:0]      max_entries,
   input  logic [dopq_pkg::MAXB_W-1:0]     max_bytes,
   // memory side
   output logic                            wr_en,
   output logic [AW-1:0]                   wr_addr,
   output logic [dopq_pkg::TAG_W-1:0]      wr_tag,
   output logic [dopq_pkg::LEN_W-1:0]      wr_len,
   output logic [AW-1:0]                   rd_addr,
   input  logic [dopq_pkg::LEN_W-1:0]      rd_len,
   // result side
   output dopq_pkg::rsp_flags_type         rsp_ff,
   output logic [CW-1:0]                   count_ff,
   output logic [dopq_pkg::BYTES_W-1:0]    bytes_ff,
   output logic [dopq_pkg::CNT_W-1:0]      pushes_ff,
   output logic [dopq_pkg::CNT_W-1:0]      drops_ff,
   output logic [dopq_pkg::CNT_W-1:0]      drains_ff,
   output logic [CW-1:0]                   peak_ff
);

   dopq_pkg::state_type state_ff, state_in;
   dopq_pkg::rsp_flags_type rsp_in;

   logic [AW-1:0]                  head_ff, head_in;
   logic [AW-1:0]                  ptr_ff, ptr_in;
   logic [CW-1:0]                  left_ff, left_in;
   logic [CW-1:0]                  count_in, peak_in;
   logic [dopq_pkg::BYTES_W-1:0]   bytes_in;
   logic [dopq_pkg::CNT_W-1:0]     pushes_in, drops_in, drains_in;
   logic [dopq_pkg::LEN_W-1:0]     len_ff, len_in;
   logic [dopq_pkg::TAG_W-1:0]     tag_ff, tag_in;
   logic                           kept_ff, kept_in;

   logic [AW-1:0]   head_inc, ptr_inc, slot;
   logic [AW:0]     slot_sum;
   logic [CW-1:0]   count_inc;
   logic [7:0]      count_plus;
   logic [24:0]     bytes_sum;
   logic            over_entries, over_bytes, drop_needed;

   assign busy = (state_ff != dopq_pkg::S_IDLE);

   // shared compare unit: one decision per cycle
   assign count_plus   = 8'(count_ff) + 8'd1;
   assign over_entries = (count_plus > {1'b0, max_entries}) || (count_plus > 8'(DEPTH));
   assign bytes_sum    = 25'(bytes_ff) + 25'(len_ff);
   assign over_bytes   = bytes_sum > 25'(max_bytes);
   assign drop_needed  = (count_ff != '0) && (over_entries || over_bytes);
   assign count_inc    = count_ff + CW'(1);

   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign ptr_inc  = (ptr_ff == AW'(DEPTH - 1)) ? '0 : ptr_ff + AW'(1);
   assign slot_sum = (AW+1)'(head_ff) + (AW+1)'(count_ff);
   assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                  : slot_sum[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dopq_pkg::S_IDLE: begin
            if (start) begin
               if (req_command == dopq_pkg::CMD_PUSH) begin
                  state_in = dopq_pkg::S_CHECK;
               end else if (req_command == dopq_pkg::CMD_DRAIN && count_ff != '0) begin
                  state_in = dopq_pkg::S_DRAIN;
               end
            end
         end
         dopq_pkg::S_CHECK: begin
            if (!drop_needed) begin
               state_in = dopq_pkg::S_IDLE;
            end
         end
         dopq_pkg::S_DRAIN: begin
            if (left_ff == CW'(1)) begin
               state_in = dopq_pkg::S_IDLE;
            end
         end
         default: state_in = dopq_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in   = head_ff;
      ptr_in    = ptr_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      bytes_in  = bytes_ff;
      pushes_in = pushes_ff;
      drops_in  = drops_ff;
      drains_in = drains_ff;
      peak_in   = peak_ff;
      len_in    = len_ff;
      tag_in    = tag_ff;
      kept_in   = kept_ff;
      rsp_in    = '0;
      rd_addr   = head_ff;
      wr_en     = 1'b0;
      wr_addr   = slot;
      wr_tag    = tag_ff;
      wr_len    = len_ff;
      case (state_ff)
         dopq_pkg::S_IDLE: begin
            if (start) begin
               case (req_command)
                  dopq_pkg::CMD_PUSH: begin
                     len_in  = dopq_pkg::sat_length(req_packet_length);
                     tag_in  = req_packet_tag;
                     kept_in = 1'b1;
                  end
                  dopq_pkg::CMD_DRAIN: begin
                     ptr_in    = head_ff;
                     left_in   = count_ff;
                     count_in  = '0;
                     bytes_in  = '0;
                     head_in   = '0;
                     drains_in = drains_ff + dopq_pkg::CNT_W'(count_ff);
                     if (count_ff == '0) begin
                        rsp_in.strobe = 1'b1;
                        rsp_in.last   = 1'b1;
                     end
                  end
                  dopq_pkg::CMD_CLEAR: begin
                     count_in      = '0;
                     bytes_in      = '0;
                     head_in       = '0;
                     rsp_in.strobe = 1'b1;
                     rsp_in.last   = 1'b1;
                  end
                  default: begin
                     pushes_in     = '0;
                     drops_in      = '0;
                     drains_in     = '0;
                     peak_in       = '0;
                     rsp_in.strobe = 1'b1;
                     rsp_in.last   = 1'b1;
                  end
               endcase
            end
         end
         dopq_pkg::S_CHECK: begin
            if (drop_needed) begin
               // retire the head; prefetch the next head's length
               bytes_in = bytes_ff - dopq_pkg::BYTES_W'(rd_len);
               head_in  = head_inc;
               rd_addr  = head_inc;
               count_in = count_ff - CW'(1);
               drops_in = drops_ff + dopq_pkg::CNT_W'(1);
               kept_in  = 1'b0;
            end else begin
               wr_en     = 1'b1;
               count_in  = count_inc;
               bytes_in  = bytes_ff + dopq_pkg::BYTES_W'(len_ff);
               pushes_in = pushes_ff + dopq_pkg::CNT_W'(1);
               if (count_inc > peak_ff) begin
                  peak_in = count_inc;
               end
               rsp_in.strobe   = 1'b1;
               rsp_in.last     = 1'b1;
               rsp_in.kept_all = kept_ff;
            end
         end
         dopq_pkg::S_DRAIN: begin
            rd_addr          = ptr_ff;
            ptr_in           = ptr_inc;
            left_in          = left_ff - CW'(1);
            rsp_in.strobe    = 1'b1;
            rsp_in.has_entry = 1'b1;
            rsp_in.last      = (left_ff == CW'(1));
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dopq_pkg::S_IDLE;
         rsp_ff    <= '0;
         head_ff   <= '0;
         count_ff  <= '0;
         bytes_ff  <= '0;
         pushes_ff <= '0;
         drops_ff  <= '0;
         drains_ff <= '0;
         peak_ff   <= '0;
         ptr_ff    <= '0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rsp_ff    <= rsp_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         bytes_ff  <= bytes_in;
         pushes_ff <= pushes_in;
         drops_ff  <= drops_in;
         drains_ff <= drains_in;
         peak_ff   <= peak_in;
         ptr_ff    <= ptr_in;
         left_ff   <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      tag_ff  <= tag_in;
      kept_ff <= kept_in;
   end

   a_drain_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == dopq_pkg::S_DRAIN |-> left_ff != '0)
      else $error("drain walk with nothing left");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   a_push_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.strobe && $past(state_ff == dopq_pkg::S_CHECK) |-> count_ff != '0)
      else $error("push beat with empty queue");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.strobe && rsp_ff.has_entry |-> count_ff == '0 && bytes_ff == '0)
      else $error("drained entry while queue not emptied");

   a_check_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == dopq_pkg::S_CHECK && count_ff == '0 |=> state_ff == dopq_pkg::S_IDLE)
      else $error("drop on empty queue");

endmodule

/* test/drop_oldest_packet_queue_tb.sv */
`timescale 1ns / 1ps

module drop_oldest_packet_queue_tb;

   localparam int unsigned QUEUE_DEPTH    = 64;
   // quiet cycles allowed before the run is called hung: the longest quiet
   // stretch is a sender gap followed by a push that drops a full queue
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   // one result beat, as seen on the rsp_ ports
   typedef struct {
      logic                           has_entry;
      logic [dopq_pkg::TAG_W-1:0]     entry_tag;
      logic [dopq_pkg::LEN_W-1:0]     entry_length;
      logic                           last;
      logic                           kept_all;
      logic [dopq_pkg::OCC_W-1:0]     occupancy;
      logic [dopq_pkg::BYTES_W-1:0]   byte_total;
      logic [dopq_pkg::CNT_W-1:0]     pushed_count;
      logic [dopq_pkg::CNT_W-1:0]     dropped_count;
      logic [dopq_pkg::CNT_W-1:0]     drained_count;
      logic [dopq_pkg::OCC_W-1:0]     peak_occupancy;
   } queue_beat_type;

   // Mirrors the descriptor queue and holds the beats still owed by the DUT.
   class queue_scoreboard;
      logic [dopq_pkg::TAG_W-1:0]   tag_mem [QUEUE_DEPTH];
      logic [dopq_pkg::LEN_W-1:0]   len_mem [QUEUE_DEPTH];
      logic [5:0]                   head;
      logic [dopq_pkg::OCC_W-1:0]   count;
      logic [dopq_pkg::BYTES_W-1:0] bytes;
      logic [dopq_pkg::CNT_W-1:0]   pushes;
      logic [dopq_pkg::CNT_W-1:0]   drops;
      logic [dopq_pkg::CNT_W-1:0]   drains;
      logic [dopq_pkg::OCC_W-1:0]   peak;
      logic [dopq_pkg::OCC_W-1:0]   entry_limit;
      logic [dopq_pkg::MAXB_W-1:0]  byte_limit;
      queue_beat_type               owed_beats [$];
      int unsigned                  fail_count;

      function new();
         head        = '0;
         count       = '0;
         bytes       = '0;
         pushes      = '0;
         drops       = '0;
         drains      = '0;
         peak        = '0;
         entry_limit = dopq_pkg::MAX_ENTRIES_RESET;
         byte_limit  = dopq_pkg::MAX_BYTES_RESET;
         fail_count  = 0;
      endfunction

      function int unsigned pending();
         return owed_beats.size();
      endfunction

      function void set_register(logic index, logic [dopq_pkg::CSR_W-1:0] data);
         if (index == dopq_pkg::REG_MAX_ENTRIES)
            entry_limit = data[dopq_pkg::OCC_W-1:0];
         else
            byte_limit = data[dopq_pkg::MAXB_W-1:0];
      endfunction

      function void owe_beat(logic has, logic [dopq_pkg::TAG_W-1:0] tag,
                             logic [dopq_pkg::LEN_W-1:0] len, logic fin, logic kept);
         queue_beat_type b;
         b.has_entry      = has;
         b.entry_tag      = tag;
         b.entry_length   = len;
         b.last           = fin;
         b.kept_all       = kept;
         b.occupancy      = count;
         b.byte_total     = bytes;
         b.pushed_count   = pushes;
         b.dropped_count  = drops;
         b.drained_count  = drains;
         b.peak_occupancy = peak;
         owed_beats.insert(owed_beats.size(), b);
      endfunction

      // accepted command beat: advance the mirror and queue up its results
      function void note_command(logic [dopq_pkg::CMD_W-1:0] cmd,
                                 logic [dopq_pkg::LEN_W-1:0] length,
                                 logic [dopq_pkg::TAG_W-1:0] tag);
         int unsigned                cap;
         int unsigned                n;
         logic [dopq_pkg::LEN_W-1:0] len;
         logic [5:0]                 slot;
         logic [5:0]                 oldest;
         logic                       kept;
         case (cmd)
            dopq_pkg::CMD_PUSH: begin
               cap  = (32'(entry_limit) > QUEUE_DEPTH) ? QUEUE_DEPTH : 32'(entry_limit);
               len  = (length > dopq_pkg::MAX_LENGTH) ? dopq_pkg::MAX_LENGTH : length;
               kept = 1'b1;
               while (count != 0 && (32'(count) + 1 > cap ||
                      32'(bytes) + 32'(len) > 32'(byte_limit))) begin
                  bytes = bytes - dopq_pkg::BYTES_W'(len_mem[head]);
                  head  = head + 6'd1;
                  count = count - dopq_pkg::OCC_W'(1);
                  drops = drops + 32'd1;
                  kept  = 1'b0;
               end
               slot          = head + count[5:0];
               tag_mem[slot] = tag;
               len_mem[slot] = len;
               count         = count + dopq_pkg::OCC_W'(1);
               bytes         = bytes + dopq_pkg::BYTES_W'(len);
               pushes        = pushes + 32'd1;
               if (count > peak)
                  peak = count;
               owe_beat(1'b0, '0, '0, 1'b1, kept);
            end
            dopq_pkg::CMD_DRAIN: begin
               n      = 32'(count);
               oldest = head;
               count  = '0;
               bytes  = '0;
               head   = '0;
               drains = drains + n;
               if (n == 0)
                  owe_beat(1'b0, '0, '0, 1'b1, 1'b0);
               for (int i = 0; i < n; i++) begin
                  slot = oldest + 6'(i);
                  owe_beat(1'b1, tag_mem[slot], len_mem[slot], i == n - 1, 1'b0);
               end
            end
            dopq_pkg::CMD_CLEAR: begin
               count = '0;
               bytes = '0;
               head  = '0;
               owe_beat(1'b0, '0, '0, 1'b1, 1'b0);
            end
            default: begin
               pushes = '0;
               drops  = '0;
               drains = '0;
               peak   = '0;
               owe_beat(1'b0, '0, '0, 1'b1, 1'b0);
            end
         endcase
      endfunction

      task report(string what);
         fail_count++;
         $display("%0t ns: %s", $realtime, what);
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s: got %0h, expected %0h", name, got, want));
      endtask

      task check_beat(queue_beat_type got);
         queue_beat_type want;
         if (owed_beats.size() == 0) begin
            report("result beat with nothing outstanding");
            return;
         end
         want = owed_beats[0];
         owed_beats.delete(0);
         check_field("has_entry", 32'(got.has_entry), 32'(want.has_entry));
         check_field("entry_tag", 32'(got.entry_tag), 32'(want.entry_tag));
         check_field("entry_length", 32'(got.entry_length), 32'(want.entry_length));
         check_field("last", 32'(got.last), 32'(want.last));
         check_field("kept_all", 32'(got.kept_all), 32'(want.kept_all));
         check_field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
         check_field("byte_total", 32'(got.byte_total), 32'(want.byte_total));
         check_field("pushed_count", 32'(got.pushed_count), 32'(want.pushed_count));
         check_field("dropped_count", 32'(got.dropped_count), 32'(want.dropped_count));
         check_field("drained_count", 32'(got.drained_count), 32'(want.drained_count));
         check_field("peak_occupancy", 32'(got.peak_occupancy),
                     32'(want.peak_occupancy));
      endtask
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [dopq_pkg::CMD_W-1:0]     req_command = dopq_pkg::CMD_PUSH;
   logic [dopq_pkg::LEN_W-1:0]     req_packet_length = '0;
   logic [dopq_pkg::TAG_W-1:0]     req_packet_tag = '0;
   logic                           rsp_strobe;
   logic                           rsp_has_entry;
   logic [dopq_pkg::TAG_W-1:0]     rsp_entry_tag;
   logic [dopq_pkg::LEN_W-1:0]     rsp_entry_length;
   logic                           rsp_last;
   logic                           rsp_kept_all;
   logic [dopq_pkg::OCC_W-1:0]     rsp_occupancy;
   logic [dopq_pkg::BYTES_W-1:0]   rsp_byte_total;
   logic [dopq_pkg::CNT_W-1:0]     rsp_pushed_count;
   logic [dopq_pkg::CNT_W-1:0]     rsp_dropped_count;
   logic [dopq_pkg::CNT_W-1:0]     rsp_drained_count;
   logic [dopq_pkg::OCC_W-1:0]     rsp_peak_occupancy;
   logic                           csr_write = 1'b0;
   logic                           csr_index = dopq_pkg::REG_MAX_ENTRIES;
   logic [dopq_pkg::CSR_W-1:0]     csr_data = '0;

   queue_scoreboard    sb = new();
   int unsigned        idle_cycles = 0;
   // sender idling comes in stretches: some with gaps, some back to back
   int unsigned        stretch_left = 0;
   bit                 back_to_back = 1'b0;

   drop_oldest_packet_queue i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_packet_length  (req_packet_length),
      .req_packet_tag     (req_packet_tag),
      .rsp_strobe         (rsp_strobe),
      .rsp_has_entry      (rsp_has_entry),
      .rsp_entry_tag      (rsp_entry_tag),
      .rsp_entry_length   (rsp_entry_length),
      .rsp_last           (rsp_last),
      .rsp_kept_all       (rsp_kept_all),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_byte_total     (rsp_byte_total),
      .rsp_pushed_count   (rsp_pushed_count),
      .rsp_dropped_count  (rsp_dropped_count),
      .rsp_drained_count  (rsp_drained_count),
      .rsp_peak_occupancy (rsp_peak_occupancy),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result monitor: the receiver cannot stall, so every strobed beat is
   // taken at the edge closing its cycle. Values read here are the ones
   // present just before the edge.
   always @(posedge clock) begin
      queue_beat_type got;
      if (!reset && rsp_strobe) begin
         got.has_entry      = rsp_has_entry;
         got.entry_tag      = rsp_entry_tag;
         got.entry_length   = rsp_entry_length;
         got.last           = rsp_last;
         got.kept_all       = rsp_kept_all;
         got.occupancy      = rsp_occupancy;
         got.byte_total     = rsp_byte_total;
         got.pushed_count   = rsp_pushed_count;
         got.dropped_count  = rsp_dropped_count;
         got.drained_count  = rsp_drained_count;
         got.peak_occupancy = rsp_peak_occupancy;
         sb.check_beat(got);
      end
   end

   // Watchdog: any command or result beat counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Sends one command beat. Start is left high after acceptance so that a
   // back-to-back beat never lowers and raises it in the same step.
   task issue(logic [dopq_pkg::CMD_W-1:0] cmd, logic [dopq_pkg::LEN_W-1:0] len,
              logic [dopq_pkg::TAG_W-1:0] tag);
      int unsigned gap;
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(5, 30);
         back_to_back = ($urandom_range(0, 2) == 0);
      end
      stretch_left--;
      gap = back_to_back ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_command       <= cmd;
      req_packet_length <= len;
      req_packet_tag    <= tag;
      do
         @(posedge clock);
      while (busy);
      sb.note_command(cmd, len, tag);
   endtask

   // Holds the sender off until every owed beat has come back. With settle
   // set it also lets the DUT go quiet, ahead of a register write.
   task wait_for_results(bit settle);
      start <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
      if (settle) begin
         while (busy) @(posedge clock);
         repeat (4) @(posedge clock);
      end
   endtask

   // csr_write stays high across both writes; lowered by the caller
   task write_reg(logic index, logic [dopq_pkg::CSR_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      sb.set_register(index, data);
   endtask

   // max_entries is written with random junk above its seven bits
   task configure(logic [dopq_pkg::OCC_W-1:0] entries,
                  logic [dopq_pkg::MAXB_W-1:0] byte_cap);
      wait_for_results(1'b1);
      write_reg(dopq_pkg::REG_MAX_ENTRIES, {17'($urandom), entries});
      write_reg(dopq_pkg::REG_MAX_BYTES, byte_cap);
      csr_write <= 1'b0;
   endtask

   task run_phase(logic [dopq_pkg::OCC_W-1:0] entries,
                  logic [dopq_pkg::MAXB_W-1:0] byte_cap,
                  int unsigned beats, int unsigned push_pct, int unsigned len_cap);
      int unsigned                roll;
      logic [dopq_pkg::CMD_W-1:0] cmd;
      logic [dopq_pkg::LEN_W-1:0] len;
      configure(entries, byte_cap);
      for (int i = 0; i < beats; i++) begin
         // mid-phase, and now and then, let the queue of owed beats run dry
         if (i == beats / 2 || $urandom_range(0, 39) == 0)
            wait_for_results(1'b0);
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            cmd = dopq_pkg::CMD_PUSH;
         else if (roll < push_pct + (100 - push_pct) / 2)
            cmd = dopq_pkg::CMD_DRAIN;
         else if ($urandom_range(0, 1) == 0)
            cmd = dopq_pkg::CMD_CLEAR;
         else
            cmd = dopq_pkg::CMD_STATS;
         roll = $urandom_range(0, 99);
         if (roll < 8)
            len = 16'($urandom);
         else if (roll < 13)
            len = '0;
         else if (roll < 16)
            len = dopq_pkg::MAX_LENGTH;
         else
            len = 16'($urandom_range(0, len_cap));
         issue(cmd, len, $urandom);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset limits, empty drain first
      issue(dopq_pkg::CMD_DRAIN, 16'd0, 32'd0);
      issue(dopq_pkg::CMD_PUSH, 16'd0, 32'd0);
      issue(dopq_pkg::CMD_PUSH, dopq_pkg::MAX_LENGTH, 32'hFFFF_FFFF);
      issue(dopq_pkg::CMD_PUSH, 16'd1234, $urandom);
      issue(dopq_pkg::CMD_DRAIN, 16'd0, 32'd0);
      issue(dopq_pkg::CMD_CLEAR, 16'd0, 32'd0);
      issue(dopq_pkg::CMD_PUSH, 16'd10, $urandom);
      issue(dopq_pkg::CMD_PUSH, 16'd20, $urandom);
      issue(dopq_pkg::CMD_STATS, 16'hFFFF, 32'hFFFF_FFFF);
      issue(dopq_pkg::CMD_CLEAR, 16'd0, 32'd0);
      issue(dopq_pkg::CMD_DRAIN, 16'd0, 32'd0);
      issue(dopq_pkg::CMD_PUSH, 16'd7, $urandom);

      // zero entry limit: each push displaces everything older
      configure(7'd0, dopq_pkg::MAX_BYTES_RESET);
      issue(dopq_pkg::CMD_PUSH, 16'd5, $urandom);
      issue(dopq_pkg::CMD_PUSH, 16'd6, $urandom);
      issue(dopq_pkg::CMD_DRAIN, 16'd0, 32'd0);

      // entry limit above depth, tight byte limit, oversize push kept alone
      configure(7'd127, 24'd100);
      issue(dopq_pkg::CMD_PUSH, 16'd40, $urandom);
      issue(dopq_pkg::CMD_PUSH, 16'd50, $urandom);
      issue(dopq_pkg::CMD_PUSH, 16'd20, $urandom);
      issue(dopq_pkg::CMD_PUSH, 16'd500, $urandom);
      issue(dopq_pkg::CMD_PUSH, 16'd0, $urandom);
      issue(dopq_pkg::CMD_DRAIN, 16'd0, 32'd0);

      // single entry, zero bytes
      configure(7'd1, 24'd0);
      issue(dopq_pkg::CMD_PUSH, 16'd0, $urandom);
      issue(dopq_pkg::CMD_PUSH, 16'd0, $urandom);
      issue(dopq_pkg::CMD_PUSH, 16'd9, $urandom);
      issue(dopq_pkg::CMD_STATS, 16'd0, 32'd0);
      issue(dopq_pkg::CMD_DRAIN, 16'd0, 32'd0);

      // random: mostly pushes early on so the queue fills and wraps
      run_phase(7'd64, dopq_pkg::MAX_BYTES_RESET, 90, 96, 1500);
      run_phase(7'd127, dopq_pkg::MAX_BYTES_RESET, 70, 96, 65535);
      run_phase(7'd5, 24'd3000, 50, 75, 1200);
      run_phase(7'd0, 24'd0, 30, 70, 50);
      run_phase(7'd2, 24'd65535, 40, 75, 40000);
      repeat (5) begin
         run_phase(7'($urandom_range(0, 127)),
                   ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 20000))
                                               : 24'($urandom),
                   30, 80, 2000);
      end

      // drain out; the watchdog bounds both waits
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
